// ===== hdl/tss_pkg.sv =====
// Shared types, constants and controller/datapath interface structs for the tuning store.
package tss_pkg;

	localparam int DEF_FREQ_SLOTS         = 8192;
	localparam int DEF_NUM_ANTENNA_BLOCKS = 4;
	localparam int DEF_SEARCH_REACH       = 5;

	localparam int CMD_W     = 2;
	localparam int ANT_W     = 3;
	localparam int FREQ_W    = 13;
	localparam int CODE_W    = 8;
	localparam int MAXF_W    = 14;
	localparam int MOFF_W    = 4;
	localparam int PROBE_W   = 16;
	localparam int ENTRY_W   = 18;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 24;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [MAXF_W-1:0] MAXF_RESET = 14'd6149;

	localparam int ENTRY_VALID_BIT = 17;
	localparam int ENTRY_HIGHZ_BIT = 16;

	// register select is paddr[2]
	localparam logic REG_ATU_ENABLED   = 1'b0;
	localparam logic REG_MAX_FREQUENCY = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_ERASE  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_HIT,
		RES_MISS,
		RES_STORE,
		RES_STORE_BAD
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     probe_init;
		logic     issue;
		logic     sweep_init;
		logic     sweep_step;
		logic     sweep_wr;
		logic     store_wr;
		logic     res_load;
		res_sel_t res_sel;
		logic     load_out;
	} tss_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic blk_ok;
		logic store_ok;
		logic probe_last;
		logic valid_s1;
		logic hit_s1;
		logic last_s1;
		logic sweep_last;
	} tss_stat_t;

endpackage

// ===== hdl/tss_ram.sv =====
// Generic single-port RAM with registered read.
module tss_ram import tss_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = DEF_NUM_ANTENNA_BLOCKS * DEF_FREQ_SLOTS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hdl/tss_regs.sv =====
// APB configuration registers: ATU enable and frequency slot limit.
module tss_regs import tss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic              atu_enabled,
	output logic [MAXF_W-1:0] max_frequency
);

	logic              atu_enabled_q;
	logic [MAXF_W-1:0] max_frequency_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atu_enabled_q   <= 1'b0;
			max_frequency_q <= MAXF_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ATU_ENABLED:   atu_enabled_q   <= pwdata[0];
				REG_MAX_FREQUENCY: max_frequency_q <= pwdata[MAXF_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ATU_ENABLED:   prdata = {{(APB_DW-1){1'b0}}, atu_enabled_q};
			REG_MAX_FREQUENCY: prdata = {{(APB_DW-MAXF_W){1'b0}}, max_frequency_q};
			default:           prdata = '0;
		endcase
	end

	assign atu_enabled   = atu_enabled_q;
	assign max_frequency = max_frequency_q;

endmodule

// ===== hdl/tss_dp.sv =====
// Datapath: item capture, probe address generation, sweep counter, result and output registers.
module tss_dp import tss_pkg::*; #(
	parameter int FREQ_SLOTS         = DEF_FREQ_SLOTS,
	parameter int NUM_ANTENNA_BLOCKS = DEF_NUM_ANTENNA_BLOCKS,
	parameter int SEARCH_REACH       = DEF_SEARCH_REACH,
	parameter int AW                 = $clog2(DEF_NUM_ANTENNA_BLOCKS * DEF_FREQ_SLOTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tss_ctrl_t          ctrl,
	output tss_stat_t          stat,
	input  logic [CMD_W-1:0]   command,
	input  logic [ANT_W-1:0]   antenna,
	input  logic [FREQ_W-1:0]  frequency,
	input  logic               success,
	input  logic [CODE_W-1:0]  inductance,
	input  logic [CODE_W-1:0]  capacitance,
	input  logic               high_z,
	input  logic               atu_enabled,
	input  logic [MAXF_W-1:0]  max_frequency,
	output logic               mem_we,
	output logic               mem_re,
	output logic [AW-1:0]      mem_addr,
	output logic [ENTRY_W-1:0] mem_wdata,
	input  logic [ENTRY_W-1:0] mem_rdata,
	output logic               found,
	output logic               solution_high_z,
	output logic [CODE_W-1:0]  solution_inductance,
	output logic [CODE_W-1:0]  solution_capacitance,
	output logic [MOFF_W-1:0]  match_offset,
	output logic               report,
	output logic               status
);

	localparam int DEPTH = NUM_ANTENNA_BLOCKS * FREQ_SLOTS;
	localparam int OFF_W = $clog2(SEARCH_REACH + 1) + 1;

	// captured item
	cmd_t              cmd_q;
	logic [FREQ_W-1:0] freq_q;
	logic              success_q;
	logic [CODE_W-1:0] ind_q;
	logic [CODE_W-1:0] cap_q;
	logic              hz_q;
	logic              blk_ok_q;
	logic [AW-1:0]     base_q;

	logic [ANT_W-1:0]  blk;

	// probe sequence
	logic signed [OFF_W-1:0]   off_q;
	logic signed [OFF_W-1:0]   off_n;
	logic signed [PROBE_W-1:0] probe;
	logic                      probe_in;
	logic [AW-1:0]             probe_addr;
	logic [AW-1:0]             store_addr;
	logic [MAXF_W-1:0]         limit;

	logic                      valid_s1;
	logic                      in_range_s1;
	logic                      last_s1;
	logic signed [OFF_W-1:0]   off_s1;
	logic                      hit_s1;

	// sweep
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] sweep_end_q;

	// result
	logic              res_found_q;
	logic              res_hz_q;
	logic [CODE_W-1:0] res_ind_q;
	logic [CODE_W-1:0] res_cap_q;
	logic [MOFF_W-1:0] res_moff_q;
	logic              res_report_q;
	logic              res_status_q;

	logic              out_found_q;
	logic              out_hz_q;
	logic [CODE_W-1:0] out_ind_q;
	logic [CODE_W-1:0] out_cap_q;
	logic [MOFF_W-1:0] out_moff_q;
	logic              out_report_q;
	logic              out_status_q;

	logic [ENTRY_W-1:0] store_entry;

	assign blk = (antenna == '0) ? '0 : antenna - ANT_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q     <= cmd_t'(command);
			freq_q    <= frequency;
			success_q <= success;
			ind_q     <= inductance;
			cap_q     <= capacitance;
			hz_q      <= high_z;
			blk_ok_q  <= (32'(blk) < NUM_ANTENNA_BLOCKS);
			base_q    <= AW'(32'(blk) * FREQ_SLOTS);
		end
	end

	always_comb begin
		if (32'(max_frequency) < FREQ_SLOTS) begin
			limit = max_frequency;
		end else begin
			limit = MAXF_W'(FREQ_SLOTS);
		end
	end

	assign probe      = $signed(PROBE_W'(freq_q)) + PROBE_W'(off_q);
	assign probe_in   = !probe[PROBE_W-1] && (probe < $signed(PROBE_W'(limit)));
	assign probe_addr = base_q + AW'($unsigned(probe));
	assign store_addr = base_q + AW'(freq_q);

	// 0, -1, +1, -2, +2, ...
	assign off_n = off_q[OFF_W-1] ? (~off_q + OFF_W'(1)) : ~off_q;

	always_ff @(posedge clk) begin
		if (ctrl.probe_init) begin
			off_q <= '0;
		end else if (ctrl.issue) begin
			off_q <= off_n;
		end
		if (ctrl.issue) begin
			in_range_s1 <= probe_in;
			last_s1     <= (off_q == OFF_W'(SEARCH_REACH));
			off_s1      <= off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
		end
	end

	assign hit_s1 = valid_s1 & in_range_s1 & mem_rdata[ENTRY_VALID_BIT];

	// clearing pass after reset runs over the whole store; an erase runs over one antenna block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			sweep_end_q <= AW'(DEPTH - 1);
		end else if (ctrl.sweep_init) begin
			sweep_q     <= base_q;
			sweep_end_q <= base_q + AW'(FREQ_SLOTS - 1);
		end else if (ctrl.sweep_step) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	assign store_entry = success_q ? {1'b1, hz_q, ind_q, cap_q} : '0;

	assign mem_we    = ctrl.sweep_wr | ctrl.store_wr;
	assign mem_re    = ctrl.issue & probe_in;
	assign mem_wdata = ctrl.sweep_wr ? '0 : store_entry;

	always_comb begin
		priority if (ctrl.sweep_wr) begin
			mem_addr = sweep_q;
		end else if (ctrl.store_wr) begin
			mem_addr = store_addr;
		end else begin
			mem_addr = probe_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			res_found_q  <= 1'b0;
			res_hz_q     <= 1'b0;
			res_ind_q    <= '0;
			res_cap_q    <= '0;
			res_moff_q   <= '0;
			res_report_q <= 1'b0;
			res_status_q <= 1'b0;
			unique case (ctrl.res_sel)
				RES_ZERO: ;
				RES_HIT: begin
					res_found_q  <= 1'b1;
					res_hz_q     <= mem_rdata[ENTRY_HIGHZ_BIT];
					res_ind_q    <= mem_rdata[2*CODE_W-1:CODE_W];
					res_cap_q    <= mem_rdata[CODE_W-1:0];
					res_moff_q   <= MOFF_W'(PROBE_W'(off_s1));
					res_report_q <= atu_enabled;
				end
				RES_MISS: begin
					res_report_q <= atu_enabled;
				end
				RES_STORE: begin
					res_found_q  <= success_q;
					res_hz_q     <= store_entry[ENTRY_HIGHZ_BIT];
					res_ind_q    <= store_entry[2*CODE_W-1:CODE_W];
					res_cap_q    <= store_entry[CODE_W-1:0];
					res_report_q <= atu_enabled;
				end
				RES_STORE_BAD: begin
					res_status_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_found_q  <= res_found_q;
			out_hz_q     <= res_hz_q;
			out_ind_q    <= res_ind_q;
			out_cap_q    <= res_cap_q;
			out_moff_q   <= res_moff_q;
			out_report_q <= res_report_q;
			out_status_q <= res_status_q;
		end
	end

	assign found                = out_found_q;
	assign solution_high_z      = out_hz_q;
	assign solution_inductance  = out_ind_q;
	assign solution_capacitance = out_cap_q;
	assign match_offset         = out_moff_q;
	assign report               = out_report_q;
	assign status               = out_status_q;

	assign stat.cmd        = cmd_q;
	assign stat.blk_ok     = blk_ok_q;
	assign stat.store_ok   = blk_ok_q && ({1'b0, freq_q} < limit);
	assign stat.probe_last = (off_q == OFF_W'(SEARCH_REACH));
	assign stat.valid_s1   = valid_s1;
	assign stat.hit_s1     = hit_s1;
	assign stat.last_s1    = last_s1;
	assign stat.sweep_last = (sweep_q == sweep_end_q);

endmodule

// ===== hdl/tss_ctrl.sv =====
// Controller: clearing pass, command dispatch, probe sequencing, erase sweep and output handshake.
module tss_ctrl import tss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output tss_ctrl_t ctrl,
	input  tss_stat_t stat
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_LOOK,
		S_ERASE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   issuing_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl = '0;
		ctrl.res_sel = RES_ZERO;
		unique case (state_q)
			S_CLEAR: begin
				ctrl.sweep_wr   = 1'b1;
				ctrl.sweep_step = 1'b1;
			end
			S_IDLE: begin
				ctrl.capture = in_valid;
			end
			S_DISPATCH: begin
				unique case (stat.cmd)
					CMD_LOOKUP: begin
						if (stat.blk_ok) begin
							ctrl.probe_init = 1'b1;
						end else begin
							ctrl.res_load = 1'b1;
							ctrl.res_sel  = RES_MISS;
						end
					end
					CMD_STORE: begin
						ctrl.res_load = 1'b1;
						if (stat.store_ok) begin
							ctrl.store_wr = 1'b1;
							ctrl.res_sel  = RES_STORE;
						end else begin
							ctrl.res_sel  = RES_STORE_BAD;
						end
					end
					CMD_ERASE: begin
						ctrl.res_load   = 1'b1;
						ctrl.sweep_init = stat.blk_ok;
					end
					default: begin
						ctrl.res_load = 1'b1;
					end
				endcase
			end
			S_LOOK: begin
				priority if (stat.hit_s1) begin
					ctrl.res_load = 1'b1;
					ctrl.res_sel  = RES_HIT;
				end else if (stat.valid_s1 && stat.last_s1) begin
					ctrl.res_load = 1'b1;
					ctrl.res_sel  = RES_MISS;
				end else if (issuing_q) begin
					ctrl.issue = 1'b1;
				end
			end
			S_ERASE: begin
				ctrl.sweep_wr   = 1'b1;
				ctrl.sweep_step = 1'b1;
			end
			S_DONE: begin
				ctrl.load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			issuing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					if (stat.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (ctrl.probe_init) begin
						issuing_q <= 1'b1;
						state_q   <= S_LOOK;
					end else if (ctrl.sweep_init) begin
						state_q <= S_ERASE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LOOK: begin
					if (ctrl.res_load) begin
						issuing_q <= 1'b0;
						state_q   <= S_DONE;
					end else if (ctrl.issue && stat.probe_last) begin
						issuing_q <= 1'b0;
					end
				end
				S_ERASE: begin
					if (stat.sweep_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ctrl.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/tuning_solution_store.sv =====
// Top level of the antenna tuner solution store.
//
// Items enter on the s_axis channel: tuser carries the command (lookup, store, erase),
// tdata the antenna, frequency and store data. One result item per input item leaves
// on the m_axis channel. atu_enabled and max_frequency are set over the APB port.
// One item is worked at a time; s_axis_tready is high only while the block is idle.
// A lookup makes at most 2*SEARCH_REACH+1 table probes. The single-port store memory
// is read once per cycle, so the probe count sets the lookup time, and the erase sweep
// writes the FREQ_SLOTS entries of one block, one entry per cycle. After reset a
// clearing pass writes all NUM_ANTENNA_BLOCKS*FREQ_SLOTS entries of the store empty
// (32768 with the defaults), one per cycle; no item is taken during it, while
// configuration writes are.
// Results sit in an output register: a new item is taken while a result waits, and
// the block holds its next result until m_axis_tready takes the waiting one.
module tuning_solution_store import tss_pkg::*; #(
	parameter int FREQ_SLOTS         = DEF_FREQ_SLOTS,
	parameter int NUM_ANTENNA_BLOCKS = DEF_NUM_ANTENNA_BLOCKS,
	parameter int SEARCH_REACH       = DEF_SEARCH_REACH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// antenna[2:0], frequency[15:3], success[16], inductance[24:17],
	// capacitance[32:25], high_z[33], zero[39:34]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [CMD_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// found[0], solution_high_z[1], solution_inductance[9:2],
	// solution_capacitance[17:10], match_offset[21:18], report[22], status[23]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int DEPTH = NUM_ANTENNA_BLOCKS * FREQ_SLOTS;
	localparam int AW    = $clog2(DEPTH);

	tss_ctrl_t ctrl;
	tss_stat_t stat;

	logic               atu_enabled;
	logic [MAXF_W-1:0]  max_frequency;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;

	logic               found;
	logic               solution_high_z;
	logic [CODE_W-1:0]  solution_inductance;
	logic [CODE_W-1:0]  solution_capacitance;
	logic [MOFF_W-1:0]  match_offset;
	logic               report;
	logic               status;

	tss_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.atu_enabled   (atu_enabled),
		.max_frequency (max_frequency)
	);

	tss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	tss_dp #(
		.FREQ_SLOTS         (FREQ_SLOTS),
		.NUM_ANTENNA_BLOCKS (NUM_ANTENNA_BLOCKS),
		.SEARCH_REACH       (SEARCH_REACH),
		.AW                 (AW)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctrl                 (ctrl),
		.stat                 (stat),
		.command              (s_axis_tuser),
		.antenna              (s_axis_tdata[2:0]),
		.frequency            (s_axis_tdata[15:3]),
		.success              (s_axis_tdata[16]),
		.inductance           (s_axis_tdata[24:17]),
		.capacitance          (s_axis_tdata[32:25]),
		.high_z               (s_axis_tdata[33]),
		.atu_enabled          (atu_enabled),
		.max_frequency        (max_frequency),
		.mem_we               (mem_we),
		.mem_re               (mem_re),
		.mem_addr             (mem_addr),
		.mem_wdata            (mem_wdata),
		.mem_rdata            (mem_rdata),
		.found                (found),
		.solution_high_z      (solution_high_z),
		.solution_inductance  (solution_inductance),
		.solution_capacitance (solution_capacitance),
		.match_offset         (match_offset),
		.report               (report),
		.status               (status)
	);

	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	assign m_axis_tdata = {status, report, match_offset, solution_capacitance,
		solution_inductance, solution_high_z, found};

endmodule

// ===== bench/tuning_solution_store_tb.sv =====
// Self-checking testbench for the tuning solution store: directed and random commands.
module tuning_solution_store_tb;
	import tss_pkg::*;

	localparam int SLOTS        = DEF_FREQ_SLOTS;
	localparam int BLOCKS       = DEF_NUM_ANTENNA_BLOCKS;
	localparam int REACH        = DEF_SEARCH_REACH;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ANT_W-1:0]  antenna;
		logic [FREQ_W-1:0] frequency;
		logic              success;
		logic [CODE_W-1:0] inductance;
		logic [CODE_W-1:0] capacitance;
		logic              high_z;
	} host_cmd_t;

	typedef struct packed {
		logic              found;
		logic              high_z;
		logic [CODE_W-1:0] inductance;
		logic [CODE_W-1:0] capacitance;
		logic [MOFF_W-1:0] offset;
		logic              report;
		logic              status;
	} tune_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// antenna[2:0], frequency[15:3], success[16], inductance[24:17],
	// capacitance[32:25], high_z[33], zero[39:34]
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// command[1:0]
	logic [CMD_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// found[0], solution_high_z[1], solution_inductance[9:2],
	// solution_capacitance[17:10], match_offset[21:18], report[22], status[23]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	host_cmd_t   host_cmd_q[$];
	tune_reply_t expected_reply_q[$];
	host_cmd_t   bus_cmd = '0;
	logic [ENTRY_W-1:0] solution_mirror [0:BLOCKS*SLOTS-1] = '{default: '0};
	logic               atu_en_q = 1'b0;
	logic [MAXF_W-1:0]  maxf_q = MAXF_RESET;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int cycles = 0;

	tuning_solution_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int slot_limit();
		return (maxf_q < SLOTS) ? int'(maxf_q) : SLOTS;
	endfunction

	// Applies one command to the mirror table and returns the reply it should give.
	function automatic tune_reply_t predict_reply(input host_cmd_t c);
		tune_reply_t r;
		int blk, lim, base, off, probe, s, i;
		logic [ENTRY_W-1:0] ent;
		r = '0;
		blk = (c.antenna == 0) ? 0 : int'(c.antenna) - 1;
		lim = slot_limit();
		base = blk * SLOTS;
		case (c.cmd)
			CMD_LOOKUP: begin
				if (blk < BLOCKS)
					for (s = 0; s <= 2 * REACH; s++) begin
						off = (s == 0) ? 0 : ((s % 2 == 1) ? -((s + 1) / 2) : s / 2);
						probe = int'(c.frequency) + off;
						if (probe >= 0 && probe < lim) begin
							ent = solution_mirror[base + probe];
							if (ent[ENTRY_VALID_BIT]) begin
								r.found = 1'b1;
								r.high_z = ent[ENTRY_HIGHZ_BIT];
								r.inductance = ent[15:8];
								r.capacitance = ent[7:0];
								r.offset = off[MOFF_W-1:0];
								break;
							end
						end
					end
				r.report = atu_en_q;
			end
			CMD_STORE: begin
				if (blk >= BLOCKS || int'(c.frequency) >= lim)
					r.status = 1'b1;
				else begin
					ent = '0;
					if (c.success) begin
						ent = {1'b1, c.high_z, c.inductance, c.capacitance};
						r.found = 1'b1;
						r.high_z = c.high_z;
						r.inductance = c.inductance;
						r.capacitance = c.capacitance;
					end
					solution_mirror[base + int'(c.frequency)] = ent;
					r.report = atu_en_q;
				end
			end
			CMD_ERASE: begin
				if (blk < BLOCKS)
					for (i = 0; i < SLOTS; i++)
						solution_mirror[base + i] = '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic cmp_field(input string fname, input int exp_v, input int act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			mismatches++;
		end
	endtask

	// sender
	always @(posedge clk) begin : drive_cmds
		host_cmd_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_reply_q.push_back(predict_reply(bus_cmd));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (host_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = host_cmd_q.pop_front();
					bus_cmd <= nxt;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'd0, nxt.high_z, nxt.capacitance, nxt.inductance,
						nxt.success, nxt.frequency, nxt.antenna};
					s_axis_tuser <= nxt.cmd;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_replies
		tune_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reply_q.size() == 0) begin
				$error("unexpected result item %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_reply_q.pop_front();
				cmp_field("found", int'(want.found), int'(m_axis_tdata[0]));
				cmp_field("solution_high_z", int'(want.high_z), int'(m_axis_tdata[1]));
				cmp_field("solution_inductance", int'(want.inductance),
					int'(m_axis_tdata[9:2]));
				cmp_field("solution_capacitance", int'(want.capacitance),
					int'(m_axis_tdata[17:10]));
				cmp_field("match_offset", int'($signed(want.offset)),
					int'($signed(m_axis_tdata[21:18])));
				cmp_field("report", int'(want.report), int'(m_axis_tdata[22]));
				cmp_field("status", int'(want.status), int'(m_axis_tdata[23]));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic set_reg(input logic sel, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_ATU_ENABLED)
			atu_en_q = value[0];
		else
			maxf_q = value[MAXF_W-1:0];
	endtask

	task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int ant, input int freq,
			input int ok, input int ind, input int cap, input int hz);
		host_cmd_t c;
		c.cmd = cmd;
		c.antenna = ant[ANT_W-1:0];
		c.frequency = freq[FREQ_W-1:0];
		c.success = ok[0];
		c.inductance = ind[CODE_W-1:0];
		c.capacitance = cap[CODE_W-1:0];
		c.high_z = hz[0];
		host_cmd_q.push_back(c);
	endtask

	// Frequencies cluster at the table ends and the current limit so lookups hit.
	task automatic add_random(input int n);
		int i, r, f, ant;
		logic [CMD_W-1:0] cmd;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			cmd = (r < 46) ? CMD_LOOKUP : (r < 92) ? CMD_STORE : (r < 94) ? CMD_ERASE : CMD_UNUSED;
			ant = ($urandom_range(99) < 90) ? $urandom_range(4) : $urandom_range(7, 5);
			r = $urandom_range(99);
			if (r < 35)
				f = $urandom_range(40);
			else if (r < 55)
				f = 8191 - int'($urandom_range(40));
			else if (r < 80)
				f = slot_limit() - 25 + int'($urandom_range(35));
			else
				f = $urandom_range(8191);
			if (f < 0)
				f = 0;
			if (f > 8191)
				f = 8191;
			add_cmd(cmd, ant, f, int'($urandom_range(99) < 85), $urandom_range(255),
				$urandom_range(255), $urandom_range(1));
		end
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (host_cmd_q.size() != 0 || s_axis_tvalid || expected_reply_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// full range, reporting on
		set_reg(REG_ATU_ENABLED, 1);
		set_reg(REG_MAX_FREQUENCY, 8192);
		add_cmd(CMD_LOOKUP, 1, 0, 0, 0, 0, 0);
		add_cmd(CMD_STORE, 1, 0, 1, 255, 0, 1);
		add_cmd(CMD_STORE, 1, 8191, 1, 0, 255, 0);
		add_cmd(CMD_STORE, 0, 100, 1, 'h5A, 'hA5, 0);
		add_cmd(CMD_LOOKUP, 1, 100, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 1, 95, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 0, 105, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 1, 94, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 1, 8188, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 1, 3, 0, 0, 0, 0);
		add_cmd(CMD_STORE, 2, 200, 1, 17, 34, 0);
		add_cmd(CMD_STORE, 2, 202, 1, 51, 68, 1);
		add_cmd(CMD_LOOKUP, 2, 201, 0, 0, 0, 0);
		add_cmd(CMD_STORE, 1, 100, 0, 200, 100, 1);
		add_cmd(CMD_LOOKUP, 1, 100, 0, 0, 0, 0);
		add_cmd(CMD_STORE, 4, 50, 1, 9, 8, 1);
		add_cmd(CMD_STORE, 5, 50, 1, 9, 8, 1);
		add_cmd(CMD_LOOKUP, 6, 50, 0, 0, 0, 0);
		add_cmd(CMD_ERASE, 7, 0, 0, 0, 0, 0);
		add_cmd(CMD_UNUSED, 1, 0, 1, 255, 255, 1);
		add_cmd(CMD_ERASE, 4, 0, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 4, 50, 0, 0, 0, 0);
		add_random(180);
		drain();

		// limit of one slot, reporting off, sender gaps
		set_reg(REG_ATU_ENABLED, 0);
		set_reg(REG_MAX_FREQUENCY, 1);
		send_idle_pct = 72;
		add_cmd(CMD_STORE, 1, 1, 1, 1, 2, 0);
		add_cmd(CMD_LOOKUP, 1, 5, 0, 0, 0, 0);
		add_cmd(CMD_LOOKUP, 1, 8191, 0, 0, 0, 0);
		add_cmd(CMD_STORE, 3, 0, 1, 77, 88, 1);
		add_random(100);
		drain();

		// reset limit, receiver stalls and one long hold-off
		set_reg(REG_ATU_ENABLED, 1);
		set_reg(REG_MAX_FREQUENCY, 6149);
		send_idle_pct = 0;
		stall_pct = 72;
		hold_req = 1'b1;
		add_cmd(CMD_STORE, 1, 6149, 1, 3, 4, 0);
		add_cmd(CMD_STORE, 1, 6148, 1, 3, 4, 0);
		add_random(200);
		drain();

		set_reg(REG_ATU_ENABLED, $urandom_range(1));
		set_reg(REG_MAX_FREQUENCY, $urandom_range(8192, 1));
		send_idle_pct = 22;
		stall_pct = 22;
		add_random(200);
		drain();

		set_reg(REG_ATU_ENABLED, 0);
		set_reg(REG_MAX_FREQUENCY, 8192);
		send_idle_pct = 0;
		stall_pct = 0;
		add_random(100);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
